>>> rtl/i2e_pkg.sv
// i2e_pkg: shared constants, word codes, queue status type and helper functions
// for the integer to english word tokens block; depends on nothing
package i2e_pkg;

    localparam int NUM_W       = 31;
    localparam int WORD_W      = 5;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = 10;
    localparam int BCD_W       = DIGITS * DIGIT_W;
    localparam int BIN_W       = 32;
    localparam int CONV_STEPS  = BIN_W / 2;
    localparam int GROUPS      = 4;
    localparam int SLOTS       = 5;
    localparam int POSITIONS   = GROUPS * SLOTS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [WORD_W-1:0] CODE_EMPTY    = 5'd0;
    localparam logic [WORD_W-1:0] CODE_TEEN0    = 5'd10;
    localparam logic [WORD_W-1:0] CODE_TENS0    = 5'd18;
    localparam logic [WORD_W-1:0] CODE_HUNDRED  = 5'd28;
    localparam logic [WORD_W-1:0] CODE_THOUSAND = 5'd29;
    localparam logic [WORD_W-1:0] CODE_MILLION  = 5'd30;
    localparam logic [WORD_W-1:0] CODE_BILLION  = 5'd31;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // one double-dabble step: add-3 on each digit, then shift in one bit
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd,
                                                 input logic b);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    function automatic logic digits_ok(input logic [BCD_W-1:0] bcd);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < DIGITS; i++) begin
            if (bcd[i*DIGIT_W +: DIGIT_W] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic [WORD_W-1:0] scale_code(input int g);
        logic [WORD_W-1:0] c;
        unique case (g)
            0:       c = CODE_BILLION;
            1:       c = CODE_MILLION;
            2:       c = CODE_THOUSAND;
            default: c = CODE_EMPTY;
        endcase
        return c;
    endfunction

endpackage

>>> rtl/i2e_front.sv
// i2e_front: accepts a number and converts it to decimal digits, two bits a cycle
// depends on i2e_pkg; writes the digit word into i2e_fifo
module i2e_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [i2e_pkg::NUM_W-1:0] i_number,
    output logic                      o_full,
    output logic                      o_wr,
    output logic [i2e_pkg::BCD_W-1:0] o_bcd,
    input  i2e_pkg::t_q_stat          i_q_stat
);
    import i2e_pkg::*;

    localparam int CNT_W = $clog2(CONV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONV_STEPS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_PUSH = 3'b100
    } t_front_state;

    t_front_state     r_state, n_state;
    logic [BIN_W-1:0] r_bin, n_bin;
    logic [BCD_W-1:0] r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_push) begin
                    n_bin   = {1'b0, i_number};
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = dd_step(dd_step(r_bcd, r_bin[BIN_W-1]), r_bin[BIN_W-2]);
                n_bin = {r_bin[BIN_W-3:0], 2'b00};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    assign o_full = (r_state != S_IDLE);
    assign o_wr   = (r_state == S_PUSH) && !i_q_stat.full;
    assign o_bcd  = r_bcd;

    a_digits_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) |-> digits_ok(r_bcd))
        else $error("front: converted digit out of range");

endmodule

>>> rtl/i2e_fifo.sv
// i2e_fifo: short register queue of digit words between front and back
// depends on i2e_pkg for the status struct
module i2e_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output i2e_pkg::t_q_stat o_stat
);
    import i2e_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_wr, do_rd;

    assign o_stat.full  = (r_count == CNT_FULL);
    assign o_stat.empty = (r_count == '0);
    assign do_wr        = i_wr && !o_stat.full;
    assign do_rd        = i_rd && !o_stat.empty;
    assign o_rdata      = r_mem[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (do_wr) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (do_rd) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_count = r_count + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fifo: fill count beyond depth");

endmodule

>>> rtl/i2e_back.sv
// i2e_back: decodes a digit word into word slots, sends one word a cycle
// while popped; depends on i2e_pkg; reads the digit word from i2e_fifo
module i2e_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  i2e_pkg::t_q_stat           i_q_stat,
    input  logic [i2e_pkg::BCD_W-1:0]  i_bcd,
    output logic                       o_rd,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [i2e_pkg::WORD_W-1:0] o_word_code,
    output logic                       o_last_word
);
    import i2e_pkg::*;

    localparam int GRP_W = 3 * DIGIT_W;
    localparam int EXT_W = GROUPS * GRP_W;

    typedef enum logic [1:0] {
        B_IDLE = 2'b01,
        B_RUN  = 2'b10
    } t_back_state;

    t_back_state          r_state, n_state;
    logic [WORD_W-1:0]    r_codes [POSITIONS];
    logic [WORD_W-1:0]    n_codes [POSITIONS];
    logic [POSITIONS-1:0] r_mask, n_mask;
    logic                 r_zero, n_zero;
    logic                 r_out_valid, n_out_valid;
    logic [WORD_W-1:0]    r_out_code, n_out_code;
    logic                 r_out_last, n_out_last;

    logic [EXT_W-1:0]     ext;
    logic [WORD_W-1:0]    d_codes [POSITIONS];
    logic [POSITIONS-1:0] d_mask;
    logic [POSITIONS-1:0] pick_oh, rest;
    logic [WORD_W-1:0]    sel_code, emit_code;
    logic                 emit, emit_last, load;

    // slot decode per group: digit, hundred, tens or teen, unit, scale
    always_comb begin
        logic [GRP_W-1:0]   grp;
        logic [DIGIT_W-1:0] h, t, u;
        ext = EXT_W'(i_bcd);
        for (int g = 0; g < GROUPS; g++) begin
            grp = ext[EXT_W-1-g*GRP_W -: GRP_W];
            h   = grp[3*DIGIT_W-1 -: DIGIT_W];
            t   = grp[2*DIGIT_W-1 -: DIGIT_W];
            u   = grp[DIGIT_W-1:0];
            d_codes[g*SLOTS]     = WORD_W'(h);
            d_mask[g*SLOTS]      = (h != '0);
            d_codes[g*SLOTS + 1] = CODE_HUNDRED;
            d_mask[g*SLOTS + 1]  = (h != '0);
            if (t == 4'd1) begin
                d_codes[g*SLOTS + 2] = CODE_TEEN0 + WORD_W'(u);
            end else begin
                d_codes[g*SLOTS + 2] = CODE_TENS0 + WORD_W'(t);
            end
            d_mask[g*SLOTS + 2]  = (t != '0);
            d_codes[g*SLOTS + 3] = WORD_W'(u);
            d_mask[g*SLOTS + 3]  = (t != 4'd1) && (u != '0);
            d_codes[g*SLOTS + 4] = scale_code(g);
            d_mask[g*SLOTS + 4]  = (grp != '0) && (scale_code(g) != CODE_EMPTY);
        end
    end

    // lowest pending slot goes next
    always_comb begin
        pick_oh  = r_mask & (~r_mask + 1'b1);
        rest     = r_mask & ~pick_oh;
        sel_code = '0;
        for (int i = 0; i < POSITIONS; i++) begin
            sel_code = sel_code | (r_codes[i] & {WORD_W{pick_oh[i]}});
        end
    end

    assign emit      = (r_state == B_RUN) && (!r_out_valid || i_pop);
    assign emit_code = r_zero ? CODE_EMPTY : sel_code;
    assign emit_last = r_zero || (rest == '0);
    assign load      = !i_q_stat.empty && ((r_state == B_IDLE) || (emit && emit_last));
    assign o_rd      = load;

    always_comb begin
        n_state     = r_state;
        n_codes     = r_codes;
        n_mask      = r_mask;
        n_zero      = r_zero;
        n_out_valid = r_out_valid;
        n_out_code  = r_out_code;
        n_out_last  = r_out_last;
        if (emit) begin
            n_mask      = rest;
            n_out_valid = 1'b1;
            n_out_code  = emit_code;
            n_out_last  = emit_last;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_codes = d_codes;
            n_mask  = d_mask;
            n_zero  = (d_mask == '0);
            n_state = B_RUN;
        end else if (emit && emit_last) begin
            n_state = B_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_codes    <= n_codes;
        r_mask     <= n_mask;
        r_zero     <= n_zero;
        r_out_code <= n_out_code;
        r_out_last <= n_out_last;
    end

    assign o_empty     = !r_out_valid;
    assign o_word_code = r_out_code;
    assign o_last_word = r_out_last;

    a_zero_no_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RUN && r_zero) |-> (r_mask == '0))
        else $error("back: zero number with pending slots");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !emit_last) |=> (r_state == B_RUN && r_mask != '0))
        else $error("back: word not marked last but nothing follows");

endmodule

>>> rtl/integer_to_english_word_tokens.sv
// integer_to_english_word_tokens: top level, spells a number as english word codes
// depends on i2e_pkg, i2e_front, i2e_fifo, i2e_back
//
//  channel   ports                           accepted when
//  input     push, full, i_number[30:0]      push && !full
//  result    pop, empty, o_word_code[4:0],   pop && !empty
//            o_last_word
//
// the front accepts a number, runs the two-bit-a-cycle binary to decimal loop, then writes
// the digit word into the queue, waiting there while the queue is full
// the back sends one word per cycle while pop takes them, one to sixteen words per number,
// and loads the next digit word in the cycle of the last word
// reset clears the control state, no clearing pass
// pop low holds the current word; the back stalls, the queue fills and full stays high
module integer_to_english_word_tokens #(
    parameter int QUEUE_DEPTH = i2e_pkg::QUEUE_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [i2e_pkg::NUM_W-1:0]  i_number,
    output logic                       empty,
    input  logic                       pop,
    output logic [i2e_pkg::WORD_W-1:0] o_word_code,
    output logic                       o_last_word
);
    import i2e_pkg::*;

    t_q_stat          q_stat;
    logic             q_wr, q_rd;
    logic [BCD_W-1:0] q_wdata, q_rdata;

    i2e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_number (i_number),
        .o_full   (full),
        .o_wr     (q_wr),
        .o_bcd    (q_wdata),
        .i_q_stat (q_stat)
    );

    i2e_fifo #(
        .WIDTH (BCD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_stat  (q_stat)
    );

    i2e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_bcd       (q_rdata),
        .o_rd        (q_rd),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_word_code (o_word_code),
        .o_last_word (o_last_word)
    );

endmodule

>>> tb/sv/integer_to_english_word_tokens_tb.sv
// integer_to_english_word_tokens_tb: self-checking testbench for the number speller
// drives numbers through the push/full queue side and checks every popped word code against
// hand-typed rows or an in-bench speller; depends on i2e_pkg and integer_to_english_word_tokens
`timescale 1ns / 100ps

module integer_to_english_word_tokens_tb;
    import i2e_pkg::*;

    localparam int N_DIRECTED  = 26;
    localparam int N_RANDOM    = 154;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;

    // plain number words used by the hand-typed rows
    localparam logic [WORD_W-1:0] W_ONE      = 5'd1;
    localparam logic [WORD_W-1:0] W_TWO      = 5'd2;
    localparam logic [WORD_W-1:0] W_THREE    = 5'd3;
    localparam logic [WORD_W-1:0] W_FOUR     = 5'd4;
    localparam logic [WORD_W-1:0] W_SIX      = 5'd6;
    localparam logic [WORD_W-1:0] W_SEVEN    = 5'd7;
    localparam logic [WORD_W-1:0] W_NINETEEN = 5'd19;
    localparam logic [WORD_W-1:0] W_TWENTY   = CODE_TENS0 + 5'd2;
    localparam logic [WORD_W-1:0] W_FORTY    = CODE_TENS0 + 5'd4;
    localparam logic [WORD_W-1:0] W_EIGHTY   = CODE_TENS0 + 5'd8;

    typedef struct packed {
        logic [WORD_W-1:0] code;
        logic              last;
    } t_word;

    // n_typed = 0 means the row is spelled by the bench speller
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [4:0]       n_typed;
        logic [79:0]      typed;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               push = 1'b0;
    logic [NUM_W-1:0]   i_number = '0;
    logic               pop = 1'b0;
    logic               full;
    logic               empty;
    logic [WORD_W-1:0]  o_word_code;
    logic               o_last_word;

    t_word words_due[$];
    int    mismatches = 0;
    int    numbers_sent = 0;
    int    zeros_sent = 0;
    int    words_checked = 0;
    int    longest_spelling = 0;
    int    cycles = 0;
    bit    send_burst = 1'b0;
    bit    sink_burst = 1'b0;

    t_row dir_rows [N_DIRECTED] = '{
        {31'd0,          5'd1,  CODE_EMPTY, 75'd0},
        {31'd1,          5'd1,  W_ONE, 75'd0},
        {31'd19,         5'd1,  W_NINETEEN, 75'd0},
        {31'd20,         5'd1,  W_TWENTY, 75'd0},
        {31'd100,        5'd2,  W_ONE, CODE_HUNDRED, 70'd0},
        {31'd1000,       5'd2,  W_ONE, CODE_THOUSAND, 70'd0},
        {31'd1000000,    5'd2,  W_ONE, CODE_MILLION, 70'd0},
        {31'd1000000000, 5'd2,  W_ONE, CODE_BILLION, 70'd0},
        {31'd2147483647, 5'd16, W_TWO, CODE_BILLION,
            W_ONE, CODE_HUNDRED, W_FORTY, W_SEVEN, CODE_MILLION,
            W_FOUR, CODE_HUNDRED, W_EIGHTY, W_THREE, CODE_THOUSAND,
            W_SIX, CODE_HUNDRED, W_FORTY, W_SEVEN},
        {31'd11,         5'd0,  80'd0},
        {31'd15,         5'd0,  80'd0},
        {31'd21,         5'd0,  80'd0},
        {31'd90,         5'd0,  80'd0},
        {31'd99,         5'd0,  80'd0},
        {31'd101,        5'd0,  80'd0},
        {31'd999,        5'd0,  80'd0},
        {31'd1001,       5'd0,  80'd0},
        {31'd1000001,    5'd0,  80'd0},
        {31'd1000000001, 5'd0,  80'd0},
        {31'd100100100,  5'd0,  80'd0},
        {31'd999999999,  5'd0,  80'd0},
        {31'd123456789,  5'd0,  80'd0},
        {31'd2000000000, 5'd0,  80'd0},
        {31'd1073741824, 5'd0,  80'd0},
        {31'd1431655765, 5'd0,  80'd0},
        {31'd715827882,  5'd0,  80'd0}
    };

    integer_to_english_word_tokens i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_number    (i_number),
        .empty       (empty),
        .pop         (pop),
        .o_word_code (o_word_code),
        .o_last_word (o_last_word)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, words_due.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    // spells one number into words_due, returns the word count
    function automatic int spell_number(input logic [NUM_W-1:0] num);
        t_word       spelled[$];
        int unsigned n;
        int unsigned div;
        int unsigned grp;
        int unsigned hund;
        int unsigned rem;
        n = num;
        if (n == 0) begin
            spelled.push_back({CODE_EMPTY, 1'b0});
        end else begin
            div = 1000000000;
            for (int g = 0; g < GROUPS; g++) begin
                grp = (n / div) % 1000;
                if (grp != 0) begin
                    hund = grp / 100;
                    rem  = grp % 100;
                    if (hund != 0) begin
                        spelled.push_back({WORD_W'(hund), 1'b0});
                        spelled.push_back({CODE_HUNDRED, 1'b0});
                    end
                    if (rem >= 20) begin
                        spelled.push_back({CODE_TENS0 + WORD_W'(rem / 10), 1'b0});
                        if (rem % 10 != 0) begin
                            spelled.push_back({WORD_W'(rem % 10), 1'b0});
                        end
                    end else if (rem != 0) begin
                        spelled.push_back({WORD_W'(rem), 1'b0});
                    end
                    case (g)
                        0:       spelled.push_back({CODE_BILLION, 1'b0});
                        1:       spelled.push_back({CODE_MILLION, 1'b0});
                        2:       spelled.push_back({CODE_THOUSAND, 1'b0});
                        default: ;
                    endcase
                end
                div = div / 1000;
            end
        end
        spelled[spelled.size()-1].last = 1'b1;
        foreach (spelled[i]) begin
            words_due.push_back(spelled[i]);
        end
        return spelled.size();
    endfunction

    task automatic send_number(input logic [NUM_W-1:0] num, input int n_typed,
                               input logic [79:0] typed);
        int gap;
        int n_words;
        gap = send_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            push     <= 1'b0;
            i_number <= NUM_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_number <= num;
        do @(posedge i_clk); while (full);
        if (n_typed != 0) begin
            for (int i = 0; i < n_typed; i++) begin
                words_due.push_back({typed[79 - 5*i -: 5], i == n_typed - 1});
            end
            n_words = n_typed;
        end else begin
            n_words = spell_number(num);
        end
        if (n_words > longest_spelling) longest_spelling = n_words;
        if (num == '0) zeros_sent++;
        numbers_sent++;
    endtask

    // hold off until every word due has been popped
    task automatic drain_words();
        push <= 1'b0;
        do @(posedge i_clk); while (words_due.size() != 0);
    endtask

    initial begin : number_source
        logic [NUM_W-1:0] num;
        longint           built;
        int               grp;
        int               shape;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (dir_rows[r]) begin
            send_number(dir_rows[r].num, dir_rows[r].n_typed, dir_rows[r].typed);
        end
        drain_words();
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 16 == 0) send_burst = ($urandom_range(0, 3) == 0);
            if (k == N_RANDOM / 2) drain_words();
            shape = $urandom_range(0, 9);
            if (shape < 3) begin
                num = NUM_W'($urandom);
            end else if (shape == 3) begin
                num = '0;
            end else begin
                built = 0;
                for (int g = 0; g < GROUPS; g++) begin
                    case ($urandom_range(0, 4))
                        0:       grp = 0;
                        1:       grp = $urandom_range(1, 19);
                        2:       grp = $urandom_range(1, 9) * 100 + $urandom_range(0, 9) * 10;
                        3:       grp = $urandom_range(1, 9) * 100 + $urandom_range(1, 19);
                        default: grp = $urandom_range(0, 999);
                    endcase
                    if (g == 0) grp = grp % 3;
                    built = built * 1000 + grp;
                end
                if (built > 64'd2147483647) built = built - 64'd1000000000;
                num = NUM_W'(built);
            end
            send_number(num, 0, 80'd0);
        end
        push <= 1'b0;
        do @(posedge i_clk); while (words_due.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("spelled %0d numbers (%0d zero), checked %0d word codes, longest %0d words",
                 numbers_sent, zeros_sent, words_checked, longest_spelling);
        $display("directed extremes and zero groups plus %0d random numbers, %0d mismatches",
                 N_RANDOM, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin : word_sink
        t_word exp;
        int    gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (words_checked % 24 == 0) sink_burst = ($urandom_range(0, 3) == 0);
            gap = sink_burst ? 0 : $urandom_range(0, 14);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            words_checked++;
            if (words_due.size() == 0) begin
                report_mismatch($sformatf("unexpected word code %0d last %0b",
                                          o_word_code, o_last_word));
            end else begin
                exp = words_due.pop_front();
                if (o_word_code !== exp.code) begin
                    report_mismatch($sformatf("word code %0d, want %0d", o_word_code, exp.code));
                end
                if (o_last_word !== exp.last) begin
                    report_mismatch($sformatf("last word %0b, want %0b (code %0d)",
                                              o_last_word, exp.last, exp.code));
                end
            end
        end
    end

endmodule
